FILE: sv/aabb_circle_collision_assert.svh
// Assertion macros for the circle versus box collision block.
`ifndef AABB_CIRCLE_COLLISION_ASSERT_SVH
`define AABB_CIRCLE_COLLISION_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define ACC_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition holds in the cycle after the trigger.
`define ACC_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

FILE: sv/acc_pkg.sv
package acc_pkg;

	localparam int DEF_FRAC_BITS = 16;

	typedef enum logic [1:0] {
		SIDE_LEFT   = 2'd0,
		SIDE_RIGHT  = 2'd1,
		SIDE_TOP    = 2'd2,
		SIDE_BOTTOM = 2'd3
	} side_t;

	// Per-item context carried alongside the root and divide stages.
	typedef struct packed {
		logic        far;
		logic        zero;
		side_t       side;
		logic [30:0] r;
		logic        sx;
		logic        sy;
		logic [30:0] ax;
		logic [30:0] ay;
		logic [31:0] kx;
		logic [31:0] ky;
	} ctx_t;

	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647)
			return 32'h7fff_ffff;
		else if (v < -34'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

FILE: sv/aabb_circle_collision.sv
// Throughput: one request per cycle unless the output register is full and not taken;
// the square root takes one stage per result bit (32 stages) and each normal divide
// one stage per quotient bit (FRAC_BITS + 1 stages).
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset (arst_n low, asynchronous) clears all valid bits; payload registers are not reset.
module aabb_circle_collision
	import acc_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// box_x, box_y, box_width, box_height, center_x, center_y, radius
	input  logic [223:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// depth, normal_x, normal_y, contact_x, contact_y
	output logic [135:0] m_tdata,
	// hit
	output logic         m_tuser
);

	localparam int DW = 32 + FRAC_BITS;
	localparam int QW = FRAC_BITS + 1;
	localparam int SQ_N = 32;
	localparam int DV_N = FRAC_BITS + 1;
	localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
	localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: input capture
	logic               v_s1;
	logic signed [31:0] bx_s1, by_s1, cx_s1, cy_s1;
	logic [30:0]        bw_s1, bh_s1, r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bx_s1 <= s_tdata[31:0];
			by_s1 <= s_tdata[63:32];
			bw_s1 <= s_tdata[94:64];
			bh_s1 <= s_tdata[125:95];
			cx_s1 <= s_tdata[157:126];
			cy_s1 <= s_tdata[189:158];
			r_s1  <= s_tdata[220:190];
		end
	end

	// Stage 2: box edges and clamped point
	logic               v_s2;
	logic signed [33:0] bx_s2, by_s2, rt_s2, bt_s2, cx_s2, cy_s2, px_s2, py_s2;
	logic [30:0]        r_s2;
	logic signed [33:0] bx_w, by_w, cx_w, cy_w, rt_w, bt_w, px_w, py_w;

	always_comb begin
		bx_w = 34'(bx_s1);
		by_w = 34'(by_s1);
		cx_w = 34'(cx_s1);
		cy_w = 34'(cy_s1);
		rt_w = bx_w + $signed({3'b000, bw_s1});
		bt_w = by_w + $signed({3'b000, bh_s1});
		px_w = (cx_w < bx_w) ? bx_w : ((cx_w > rt_w) ? rt_w : cx_w);
		py_w = (cy_w < by_w) ? by_w : ((cy_w > bt_w) ? bt_w : cy_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bx_s2 <= bx_w;
			by_s2 <= by_w;
			rt_s2 <= rt_w;
			bt_s2 <= bt_w;
			cx_s2 <= cx_w;
			cy_s2 <= cy_w;
			px_s2 <= px_w;
			py_s2 <= py_w;
			r_s2  <= r_s1;
		end
	end

	// Stage 3: offset, early miss, nearest edge and contact
	logic               v_s3;
	ctx_t               c_s3;
	logic signed [33:0] dx_w, dy_w, dl_w, dr_w, dt_w, db_w, rr_w;
	logic [33:0]        ax_w, ay_w;
	side_t              side_w;
	logic signed [33:0] ikx_w, iky_w;
	ctx_t               c_w;

	always_comb begin
		dx_w = cx_s2 - px_s2;
		dy_w = cy_s2 - py_s2;
		ax_w = dx_w[33] ? 34'(-dx_w) : 34'(dx_w);
		ay_w = dy_w[33] ? 34'(-dy_w) : 34'(dy_w);
		dl_w = cx_s2 - bx_s2;
		dr_w = rt_s2 - cx_s2;
		dt_w = cy_s2 - by_s2;
		db_w = bt_s2 - cy_s2;
		rr_w = $signed({3'b000, r_s2});
		if (dl_w <= dr_w && dl_w <= dt_w && dl_w <= db_w)
			side_w = SIDE_LEFT;
		else if (dr_w <= dt_w && dr_w <= db_w)
			side_w = SIDE_RIGHT;
		else if (dt_w <= db_w)
			side_w = SIDE_TOP;
		else
			side_w = SIDE_BOTTOM;
		ikx_w = cx_s2;
		iky_w = cy_s2;
		case (side_w)
			SIDE_LEFT:   ikx_w = cx_s2 - rr_w;
			SIDE_RIGHT:  ikx_w = cx_s2 + rr_w;
			SIDE_TOP:    iky_w = cy_s2 - rr_w;
			SIDE_BOTTOM: iky_w = cy_s2 + rr_w;
			default:     ikx_w = cx_s2;
		endcase
		c_w.far  = (ax_w > {3'b000, r_s2}) || (ay_w > {3'b000, r_s2});
		c_w.zero = (dx_w == '0) && (dy_w == '0);
		c_w.side = side_w;
		c_w.r    = r_s2;
		c_w.sx   = dx_w[33];
		c_w.sy   = dy_w[33];
		c_w.ax   = ax_w[30:0];
		c_w.ay   = ay_w[30:0];
		c_w.kx   = c_w.zero ? sat32(ikx_w) : sat32(px_s2);
		c_w.ky   = c_w.zero ? sat32(iky_w) : sat32(py_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en)
			c_s3 <= c_w;
	end

	// Stage 4: squares
	logic        v_s4;
	ctx_t        c_s4;
	logic [61:0] xx_s4, yy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4  <= c_s3;
			xx_s4 <= c_s3.ax * c_s3.ax;
			yy_s4 <= c_s3.ay * c_s3.ay;
		end
	end

	// Stage 5 and root stages: sum of squares, then one root bit per stage
	logic        sq_v_s   [0:SQ_N];
	ctx_t        sq_c_s   [0:SQ_N];
	logic [63:0] sq_n_s   [0:SQ_N];
	logic [63:0] sq_res_s [0:SQ_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_v_s[0] <= 1'b0;
		else if (en)
			sq_v_s[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_c_s[0]   <= c_s4;
			sq_n_s[0]   <= 64'(xx_s4) + 64'(yy_s4);
			sq_res_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] trial;
		assign trial = sq_res_s[i] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[i+1] <= 1'b0;
			else if (en)
				sq_v_s[i+1] <= sq_v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_c_s[i+1] <= sq_c_s[i];
				if (sq_n_s[i] >= trial) begin
					sq_n_s[i+1]   <= sq_n_s[i] - trial;
					sq_res_s[i+1] <= (sq_res_s[i] >> 1) + BIT;
				end else begin
					sq_n_s[i+1]   <= sq_n_s[i];
					sq_res_s[i+1] <= sq_res_s[i] >> 1;
				end
			end
		end
	end

	// Divide entry and stages: |offset| * ONE / length, one quotient bit per stage
	logic          dv_v_s   [0:DV_N];
	logic          dv_hit_s [0:DV_N];
	ctx_t          dv_c_s   [0:DV_N];
	logic [31:0]   dv_len_s [0:DV_N];
	logic [DW-1:0] dv_rx_s  [0:DV_N];
	logic [DW-1:0] dv_ry_s  [0:DV_N];
	logic [QW-1:0] dv_qx_s  [0:DV_N];
	logic [QW-1:0] dv_qy_s  [0:DV_N];
	logic [31:0]   len_w;

	assign len_w = sq_res_s[SQ_N][31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_s[0] <= 1'b0;
		else if (en)
			dv_v_s[0] <= sq_v_s[SQ_N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_c_s[0]   <= sq_c_s[SQ_N];
			dv_len_s[0] <= len_w;
			dv_hit_s[0] <= !sq_c_s[SQ_N].far && (len_w <= {1'b0, sq_c_s[SQ_N].r});
			dv_rx_s[0]  <= DW'(sq_c_s[SQ_N].ax) << FRAC_BITS;
			dv_ry_s[0]  <= DW'(sq_c_s[SQ_N].ay) << FRAC_BITS;
			dv_qx_s[0]  <= '0;
			dv_qy_s[0]  <= '0;
		end
	end

	for (genvar j = 0; j < DV_N; j++) begin : g_div
		localparam int K = FRAC_BITS - j;
		logic [DW-1:0] dsr;
		assign dsr = DW'(dv_len_s[j]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[j+1] <= 1'b0;
			else if (en)
				dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_c_s[j+1]   <= dv_c_s[j];
				dv_len_s[j+1] <= dv_len_s[j];
				dv_hit_s[j+1] <= dv_hit_s[j];
				if (dv_rx_s[j] >= dsr) begin
					dv_rx_s[j+1] <= dv_rx_s[j] - dsr;
					dv_qx_s[j+1] <= dv_qx_s[j] | (QW'(1) << K);
				end else begin
					dv_rx_s[j+1] <= dv_rx_s[j];
					dv_qx_s[j+1] <= dv_qx_s[j];
				end
				if (dv_ry_s[j] >= dsr) begin
					dv_ry_s[j+1] <= dv_ry_s[j] - dsr;
					dv_qy_s[j+1] <= dv_qy_s[j] | (QW'(1) << K);
				end else begin
					dv_ry_s[j+1] <= dv_ry_s[j];
					dv_qy_s[j+1] <= dv_qy_s[j];
				end
			end
		end
	end

	// Output stage: bound and sign the normal, pick results, zero on a miss
	ctx_t               fc;
	logic [QW-1:0]      mx_w, my_w;
	logic signed [63:0] nx_w, ny_w;
	logic [30:0]        depth_w;

	assign fc = dv_c_s[DV_N];

	always_comb begin
		mx_w = (dv_qx_s[DV_N] > ONE_Q) ? ONE_Q : dv_qx_s[DV_N];
		my_w = (dv_qy_s[DV_N] > ONE_Q) ? ONE_Q : dv_qy_s[DV_N];
		if (fc.zero) begin
			nx_w = '0;
			ny_w = '0;
			case (fc.side)
				SIDE_LEFT:   nx_w = -ONE64;
				SIDE_RIGHT:  nx_w = ONE64;
				SIDE_TOP:    ny_w = -ONE64;
				SIDE_BOTTOM: ny_w = ONE64;
				default:     nx_w = '0;
			endcase
		end else begin
			nx_w = fc.sx ? -$signed(64'(mx_w)) : $signed(64'(mx_w));
			ny_w = fc.sy ? -$signed(64'(my_w)) : $signed(64'(my_w));
		end
		depth_w = fc.r - dv_len_s[DV_N][30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (en)
			m_tvalid <= dv_v_s[DV_N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser <= dv_hit_s[DV_N];
			if (dv_hit_s[DV_N])
				m_tdata <= {5'b00000, fc.ky, fc.kx, ny_w[17:0], nx_w[17:0], depth_w};
			else
				m_tdata <= '0;
		end
	end

	`include "aabb_circle_collision_assert.svh"

	`ACC_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss with nonzero payload")
	`ACC_ASSERT_NOW(a_root_fits, sq_v_s[SQ_N], sq_res_s[SQ_N][63:32] == '0, "root exceeds 32 bits")
	`ACC_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped on stall")

endmodule
